/* hw/rtl/apu_pkg.sv */
// shared types, register codes and constants of the adam parameter update core
package apu_pkg;

  typedef struct packed {
    logic [9:0]         index;
    logic signed [31:0] weight;
    logic signed [31:0] gradient;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         out_index;
    logic signed [31:0] new_weight;
    logic               out_last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] initial_rate;
    logic [23:0] decay;
    logic [23:0] beta_first;
    logic [23:0] beta_second;
    logic [31:0] epsilon;
  } cfg_t;

  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_INITIAL_RATE = 3'd0;
  localparam cfg_idx_t REG_DECAY        = 3'd1;
  localparam cfg_idx_t REG_BETA_FIRST   = 3'd2;
  localparam cfg_idx_t REG_BETA_SECOND  = 3'd3;
  localparam cfg_idx_t REG_EPSILON      = 3'd4;

  localparam logic [31:0] INITIAL_RATE_RST = 32'd4294967;
  localparam logic [23:0] DECAY_RST        = 24'd0;
  localparam logic [23:0] BETA_FIRST_RST   = 24'd15099494;
  localparam logic [23:0] BETA_SECOND_RST  = 24'd16760439;
  localparam logic [31:0] EPSILON_RST      = 32'd43;

  localparam logic [24:0] ONE_Q24    = 25'h100_0000;
  localparam logic [23:0] ROUND_Q24  = 24'h80_0000;
  localparam logic [33:0] STEP_LIMIT = 34'h2_0000_0000;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MACC,
    ST_WB,
    ST_SQRT,
    ST_RMUL,
    ST_DIV,
    ST_DWAIT,
    ST_OUT,
    ST_DECAY,
    ST_DECWB
  } back_state_t;

  typedef enum logic [2:0] {
    D_NONE,
    D_M,
    D_G2,
    D_V_LO,
    D_V_HI
  } prod_dest_t;

endpackage

/* hw/rtl/apu_ram.sv */
// generic single write port ram with registered read
module apu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/apu_sqrt.sv */
// iterative integer square root, two result bits per cycle
module apu_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [3:0]  cnt;
  logic [63:0] rad;
  logic [33:0] rem;
  logic [63:0] rad_next;
  logic [33:0] rem_next;
  logic [31:0] root_next;
  logic [35:0] trial_acc;
  logic [35:0] trial;

  always_comb begin
    rem_next  = rem;
    root_next = root;
    rad_next  = rad;
    trial_acc = '0;
    trial     = '0;
    for (int k = 0; k < 2; k++) begin
      trial_acc = {rem_next, rad_next[63:62]};
      trial     = {2'b00, root_next, 2'b01};
      if (trial_acc >= trial) begin
        rem_next  = 34'(trial_acc - trial);
        root_next = {root_next[30:0], 1'b1};
      end else begin
        rem_next  = trial_acc[33:0];
        root_next = {root_next[30:0], 1'b0};
      end
      rad_next = {rad_next[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad_next;
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule

/* hw/rtl/apu_div.sv */
// restoring divider, two quotient bits per cycle, quotient kept below 2^34
module apu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [40:0] divisor,
  output logic        done,
  output logic [33:0] quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [40:0] dvs;
  logic [40:0] rem;
  logic [40:0] rem_next;
  logic [33:0] dq_next;
  logic [41:0] part;
  logic        too_big;

  // quotient would reach 2^34: saturate right away
  assign too_big = (41'(dividend[63:34]) >= divisor);

  always_comb begin
    rem_next = rem;
    dq_next  = quotient;
    part     = '0;
    for (int k = 0; k < 2; k++) begin
      part = {rem_next, dq_next[33]};
      if (part >= {1'b0, dvs}) begin
        rem_next = 41'(part - {1'b0, dvs});
        dq_next  = {dq_next[32:0], 1'b1};
      end else begin
        rem_next = part[40:0];
        dq_next  = {dq_next[32:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (divisor == '0 || too_big) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd16) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= 41'(dividend[63:34]);
      if (divisor == '0) begin
        quotient <= '0;
      end else if (too_big) begin
        quotient <= apu_pkg::STEP_LIMIT;
      end else begin
        quotient <= dividend[33:0];
      end
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= dq_next;
    end
  end

endmodule

/* hw/rtl/apu_front.sv */
// front end: takes items, folds the index onto the store, queues them for the back end
module apu_front #(
  parameter int ELEMENTS = 1024,
  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear_busy,
  input  logic              in_valid,
  output logic              in_ready,
  input  apu_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output apu_pkg::in_item_t q_item,
  output logic [AW-1:0]     q_addr
);

  localparam int unsigned RECIP  = (32'd1 << 20) / ELEMENTS;
  localparam logic [20:0] ELEM_C = 21'(ELEMENTS);

  logic              s_valid;
  apu_pkg::in_item_t s_item;
  logic [9:0]        s_qest;
  logic [29:0]       recip_prod;
  logic [29:0]       qe;
  logic [10:0]       rest;
  logic [10:0]       rest_adj;
  logic [AW-1:0]     addr;

  apu_pkg::in_item_t fifo_item [2];
  logic [AW-1:0]     fifo_addr [2];
  logic              wptr;
  logic              rptr;
  logic [1:0]        cnt;
  logic              push;
  logic              pop;
  logic              in_fire;

  // quotient estimate, low by at most one
  assign recip_prod = 30'(in_data.index) * 30'(RECIP);

  always_comb begin
    qe   = 30'(s_qest) * 30'(ELEMENTS);
    rest = 11'(s_item.index) - qe[10:0];
    if (21'(rest) >= ELEM_C) begin
      rest_adj = rest - 11'(ELEMENTS);
    end else begin
      rest_adj = rest;
    end
    addr = AW'(rest_adj);
  end

  assign push     = s_valid && (cnt != 2'd2);
  assign in_ready = !clear_busy && (!s_valid || push);
  assign in_fire  = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = fifo_item[rptr];
  assign q_addr   = fifo_addr[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      wptr    <= 1'b0;
      rptr    <= 1'b0;
      cnt     <= '0;
    end else begin
      if (in_fire) begin
        s_valid <= 1'b1;
      end else if (push) begin
        s_valid <= 1'b0;
      end
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_item <= in_data;
      s_qest <= recip_prod[29:20];
    end
    if (push) begin
      fifo_item[wptr] <= s_item;
      fifo_addr[wptr] <= addr;
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !pop) |=> (cnt == 2'd2))
    else $error("queue overrun");
`endif

endmodule

/* hw/rtl/apu_back.sv */
// back end: moment update, square root, divide, weight update and rate decay
module apu_back #(
  parameter int ELEMENTS = 1024,
  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  apu_pkg::cfg_t      cfg,
  input  logic               rate_load,
  input  logic [31:0]        rate_value,
  input  logic               q_valid,
  output logic               q_ready,
  input  apu_pkg::in_item_t  q_item,
  input  logic [AW-1:0]      q_addr,
  output logic               clear_busy,
  output logic               out_valid,
  input  logic               out_ready,
  output apu_pkg::out_item_t out_data
);

  localparam logic [AW-1:0] CLR_LAST = AW'(ELEMENTS - 1);

  apu_pkg::back_state_t state, state_next;
  apu_pkg::prod_dest_t  dest, dest_next;

  logic [AW-1:0]      clr_cnt;
  logic [2:0]         mstep;
  apu_pkg::in_item_t  item;
  logic [AW-1:0]      addr;
  logic [31:0]        rate;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [95:0]        wr_data;
  logic               rd_en;
  logic [95:0]        rd_data;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;
  logic [57:0]        acc_m;
  logic [89:0]        acc_v;
  logic [63:0]        g2;
  logic [31:0]        m_new;
  logic [63:0]        v_new;
  logic [31:0]        m_reg;
  logic [31:0]        mag;
  logic [40:0]        den;
  logic [24:0]        c1;
  logic [24:0]        c2;
  logic [24:0]        keep;

  logic               sq_start;
  logic               sq_done;
  logic [31:0]        sq_root;
  logic               dv_start;
  logic               dv_done;
  logic [33:0]        dv_quot;

  logic               out_load;
  logic [33:0]        step_mag;
  logic [35:0]        w_ext;
  logic [35:0]        nw;
  logic [31:0]        nw_sat;

  assign c1    = apu_pkg::ONE_Q24 - {1'b0, cfg.beta_first};
  assign c2    = apu_pkg::ONE_Q24 - {1'b0, cfg.beta_second};
  assign keep  = apu_pkg::ONE_Q24 - {1'b0, cfg.decay};
  assign m_new = acc_m[55:24];
  assign v_new = acc_v[87:24];
  assign mag   = m_reg[31] ? (~m_reg + 32'd1) : m_reg;

  apu_ram #(.WIDTH(96), .DEPTH(ELEMENTS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (q_addr),
    .rd_data (rd_data)
  );

  apu_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (v_new),
    .done     (sq_done),
    .root     (sq_root)
  );

  apu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (prod[63:0]),
    .divisor  (den),
    .done     (dv_done),
    .quotient (dv_quot)
  );

  // signed weight update with saturation to 32 bits
  always_comb begin
    step_mag = (dv_quot > apu_pkg::STEP_LIMIT) ? apu_pkg::STEP_LIMIT : dv_quot;
    w_ext    = {{4{item.weight[31]}}, item.weight};
    if (m_reg[31]) begin
      nw = w_ext + {2'b00, step_mag};
    end else begin
      nw = w_ext - {2'b00, step_mag};
    end
    if (!nw[35] && (nw[34:31] != 4'b0000)) begin
      nw_sat = 32'h7FFF_FFFF;
    end else if (nw[35] && (nw[34:31] != 4'b1111)) begin
      nw_sat = 32'h8000_0000;
    end else begin
      nw_sat = nw[31:0];
    end
  end

  always_comb begin
    state_next = state;
    dest_next  = apu_pkg::D_NONE;
    q_ready    = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = addr;
    wr_data    = {m_new, v_new};
    mul_a      = '0;
    mul_b      = '0;
    sq_start   = 1'b0;
    dv_start   = 1'b0;
    out_load   = 1'b0;
    clear_busy = (state == apu_pkg::ST_CLEAR);
    unique case (state)
      apu_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
        if (clr_cnt == CLR_LAST) begin
          state_next = apu_pkg::ST_IDLE;
        end
      end
      apu_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          rd_en      = 1'b1;
          state_next = apu_pkg::ST_MUL;
        end
      end
      apu_pkg::ST_MUL: begin
        unique case (mstep)
          3'd0: begin
            mul_a     = {9'd0, cfg.beta_first};
            mul_b     = {rd_data[95], rd_data[95:64]};
            dest_next = apu_pkg::D_M;
          end
          3'd1: begin
            mul_a     = {8'd0, c1};
            mul_b     = {item.gradient[31], item.gradient};
            dest_next = apu_pkg::D_M;
          end
          3'd2: begin
            mul_a     = {item.gradient[31], item.gradient};
            mul_b     = {item.gradient[31], item.gradient};
            dest_next = apu_pkg::D_G2;
          end
          3'd3: begin
            mul_a     = {9'd0, cfg.beta_second};
            mul_b     = {1'b0, rd_data[31:0]};
            dest_next = apu_pkg::D_V_LO;
          end
          3'd4: begin
            mul_a     = {9'd0, cfg.beta_second};
            mul_b     = {1'b0, rd_data[63:32]};
            dest_next = apu_pkg::D_V_HI;
          end
          3'd5: begin
            mul_a     = {8'd0, c2};
            mul_b     = {1'b0, g2[31:0]};
            dest_next = apu_pkg::D_V_LO;
          end
          3'd6: begin
            mul_a     = {8'd0, c2};
            mul_b     = {1'b0, g2[63:32]};
            dest_next = apu_pkg::D_V_HI;
          end
          default: begin
            dest_next = apu_pkg::D_NONE;
          end
        endcase
        if (mstep == 3'd6) begin
          state_next = apu_pkg::ST_MACC;
        end
      end
      apu_pkg::ST_MACC: begin
        state_next = apu_pkg::ST_WB;
      end
      apu_pkg::ST_WB: begin
        wr_en      = 1'b1;
        sq_start   = 1'b1;
        state_next = apu_pkg::ST_SQRT;
      end
      apu_pkg::ST_SQRT: begin
        if (sq_done) begin
          state_next = apu_pkg::ST_RMUL;
        end
      end
      apu_pkg::ST_RMUL: begin
        mul_a      = {1'b0, rate};
        mul_b      = {1'b0, mag};
        state_next = apu_pkg::ST_DIV;
      end
      apu_pkg::ST_DIV: begin
        dv_start   = 1'b1;
        state_next = apu_pkg::ST_DWAIT;
      end
      apu_pkg::ST_DWAIT: begin
        if (dv_done) begin
          state_next = apu_pkg::ST_OUT;
        end
      end
      apu_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = item.last ? apu_pkg::ST_DECAY : apu_pkg::ST_IDLE;
        end
      end
      apu_pkg::ST_DECAY: begin
        mul_a      = {1'b0, rate};
        mul_b      = {8'd0, keep};
        state_next = apu_pkg::ST_DECWB;
      end
      apu_pkg::ST_DECWB: begin
        state_next = apu_pkg::ST_IDLE;
      end
      default: begin
        state_next = apu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= apu_pkg::ST_CLEAR;
      dest      <= apu_pkg::D_NONE;
      clr_cnt   <= '0;
      mstep     <= '0;
      rate      <= apu_pkg::INITIAL_RATE_RST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      dest  <= dest_next;
      if (state == apu_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == apu_pkg::ST_IDLE) begin
        mstep <= '0;
      end else if (state == apu_pkg::ST_MUL) begin
        mstep <= mstep + 3'd1;
      end
      if (rate_load) begin
        rate <= rate_value;
      end else if (state == apu_pkg::ST_DECWB) begin
        rate <= prod[55:24];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (q_valid && q_ready) begin
      item  <= q_item;
      addr  <= q_addr;
      acc_m <= 58'(apu_pkg::ROUND_Q24);
      acc_v <= 90'(apu_pkg::ROUND_Q24);
    end else begin
      unique case (dest)
        apu_pkg::D_M:    acc_m <= acc_m + prod[57:0];
        apu_pkg::D_V_LO: acc_v <= acc_v + {32'd0, prod[57:0]};
        apu_pkg::D_V_HI: acc_v <= acc_v + {prod[57:0], 32'd0};
        apu_pkg::D_G2:   g2 <= prod[63:0];
        default: begin
        end
      endcase
    end
    if (state == apu_pkg::ST_WB) begin
      m_reg <= m_new;
    end
    if (state == apu_pkg::ST_SQRT && sq_done) begin
      den <= {1'b0, sq_root, 8'd0} + 41'(cfg.epsilon);
    end
    if (out_load) begin
      out_data.out_index  <= item.index;
      out_data.new_weight <= nw_sat;
      out_data.out_last   <= item.last;
    end
  end

`ifndef SYNTH
  a_sq_done: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == apu_pkg::ST_SQRT))
    else $error("root finished outside its wait state");
  a_dv_done: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> (state == apu_pkg::ST_DWAIT))
    else $error("quotient finished outside its wait state");
  a_rate_hold: assert property (@(posedge clk) disable iff (rst)
    (state != apu_pkg::ST_DECWB && !rate_load) |=> $stable(rate))
    else $error("rate changed without decay or load");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> (state == apu_pkg::ST_MUL && mstep == 3'd0))
    else $error("item taken while back end busy");
`endif

endmodule

/* hw/rtl/adam_parameter_update_core.sv */
// top level of the adam parameter update core: register file, front end and back end
//
//   channel  direction  payload              transfer when
//   in       input      apu_pkg::in_item_t   in_valid && in_ready
//   out      output     apu_pkg::out_item_t  out_valid && out_ready
//   cfg      input      index 3b, data 32b   cfg_valid && cfg_ready
//
// items go through the back end one at a time; the radix-4 square root and the two-bit
// divider take the largest share of the work on each item.
// after reset the moment store is zeroed; no item is taken meanwhile.
// the front queue holds two items, and a finished result waits in the output register.
module adam_parameter_update_core #(
  parameter int ELEMENTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  apu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output apu_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  apu_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  apu_pkg::cfg_t     cfg;
  logic              cfg_fire;
  logic              rate_load;
  logic              clear_busy;
  logic              q_valid;
  logic              q_ready;
  apu_pkg::in_item_t q_item;
  logic [AW-1:0]     q_addr;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign rate_load = cfg_fire && (cfg_index == apu_pkg::REG_INITIAL_RATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_rate <= apu_pkg::INITIAL_RATE_RST;
      cfg.decay        <= apu_pkg::DECAY_RST;
      cfg.beta_first   <= apu_pkg::BETA_FIRST_RST;
      cfg.beta_second  <= apu_pkg::BETA_SECOND_RST;
      cfg.epsilon      <= apu_pkg::EPSILON_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        apu_pkg::REG_INITIAL_RATE: cfg.initial_rate <= cfg_data;
        apu_pkg::REG_DECAY:        cfg.decay        <= cfg_data[23:0];
        apu_pkg::REG_BETA_FIRST:   cfg.beta_first   <= cfg_data[23:0];
        apu_pkg::REG_BETA_SECOND:  cfg.beta_second  <= cfg_data[23:0];
        apu_pkg::REG_EPSILON:      cfg.epsilon      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  apu_front #(.ELEMENTS(ELEMENTS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .clear_busy (clear_busy),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .q_addr     (q_addr)
  );

  apu_back #(.ELEMENTS(ELEMENTS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rate_load  (rate_load),
    .rate_value (cfg_data),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .q_addr     (q_addr),
    .clear_busy (clear_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* tb/tb_adam_parameter_update_core.sv */
// testbench of the adam parameter update core: random and directed items checked against a predictor
`timescale 1ns / 1ps
module tb_adam_parameter_update_core;
  import apu_pkg::*;

  localparam int NUM_ELEM = 1024;
  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = REG_INITIAL_RATE;
  logic [31:0] cfg_data = '0;

  adam_parameter_update_core #(.ELEMENTS(NUM_ELEM)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [31:0] rate_init_q, rate_now_q, eps_q;
  logic [23:0] decay_q, beta1_q, beta2_q;
  logic signed [31:0] moment1 [NUM_ELEM];
  logic [63:0] moment2 [NUM_ELEM];

  in_item_t pending_items[$];
  out_item_t expected_updates[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stim_done = 0;
  // input transfer seen at the last rising edge
  bit in_taken = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic out_item_t predict_update(input in_item_t it);
    int unsigned a;
    logic signed [63:0] acc, m, nw, stepv;
    logic [127:0] vacc;
    logic [63:0] g2, v, den, mag, q;
    out_item_t r;
    a = it.index % NUM_ELEM;
    acc = $signed({1'b0, beta1_q}) * 64'(moment1[a])
        + $signed(64'(ONE_Q24) - 64'(beta1_q)) * 64'(it.gradient);
    m = (acc + 64'sd8388608) >>> 24;
    moment1[a] = m[31:0];
    g2 = 64'(64'(it.gradient) * 64'(it.gradient));
    vacc = 128'(beta2_q) * 128'(moment2[a])
         + (128'(ONE_Q24) - 128'(beta2_q)) * 128'(g2) + 128'd8388608;
    v = vacc[87:24];
    moment2[a] = v;
    den = (int_sqrt(v) << 8) + 64'(eps_q);
    stepv = 0;
    if (den != 0) begin
      mag = m < 0 ? 64'(-m) : 64'(m);
      q = (64'(rate_now_q) * mag) / den;
      if (q > 64'(STEP_LIMIT)) q = 64'(STEP_LIMIT);
      stepv = m < 0 ? -$signed(q) : $signed(q);
    end
    nw = 64'(it.weight) - stepv;
    if (nw > 64'sd2147483647) nw = 64'sd2147483647;
    if (nw < -64'sd2147483648) nw = -64'sd2147483648;
    r.out_index = it.index;
    r.new_weight = nw[31:0];
    r.out_last = it.last;
    if (it.last)
      rate_now_q = 32'((64'(rate_now_q) * (64'(ONE_Q24) - 64'(decay_q))) >> 24);
    return r;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
  endfunction

  // driver
  int in_gap = 0;
  int out_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        expected_updates.push_back(predict_update(in_data));
        void'(pending_items.pop_front());
        in_gap = short_gap();
      end
      if (!in_valid || in_taken) begin
        if (pending_items.size() > 0 && in_gap == 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = short_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      in_taken <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_updates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer %p", out_data);
        end else if (out_data !== expected_updates[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", expected_updates[0], out_data);
          void'(expected_updates.pop_front());
        end else begin
          void'(expected_updates.pop_front());
        end
      end
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("tb_adam_parameter_update_core: done, errors");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_INITIAL_RATE: begin
        rate_init_q = val;
        rate_now_q = val;
      end
      REG_DECAY: decay_q = val[23:0];
      REG_BETA_FIRST: beta1_q = val[23:0];
      REG_BETA_SECOND: beta2_q = val[23:0];
      REG_EPSILON: eps_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_updates.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic in_item_t rand_item(input bit wide);
    in_item_t it;
    it.index = wide ? 10'($urandom) : 10'($urandom_range(0, 15));
    it.weight = $urandom;
    case ($urandom_range(0, 3))
      0: it.gradient = $urandom;
      1: it.gradient = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      2: it.gradient = $signed($urandom_range(0, 2047)) - 1024;
      default: it.gradient = '0;
    endcase
    it.last = ($urandom_range(0, 15) == 0);
    return it;
  endfunction

  function automatic in_item_t mk(input logic [9:0] i, input logic [31:0] w,
                                  input logic [31:0] g, input logic l);
    in_item_t it;
    it.index = i;
    it.weight = w;
    it.gradient = g;
    it.last = l;
    return it;
  endfunction

  initial begin
    rate_init_q = INITIAL_RATE_RST;
    rate_now_q = INITIAL_RATE_RST;
    decay_q = DECAY_RST;
    beta1_q = BETA_FIRST_RST;
    beta2_q = BETA_SECOND_RST;
    eps_q = EPSILON_RST;
    for (int i = 0; i < NUM_ELEM; i++) begin
      moment1[i] = '0;
      moment2[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: default settings, field extremes
    pending_items.push_back(mk(10'd0, 32'h7fffffff, 32'h7fffffff, 1'b0));
    pending_items.push_back(mk(10'd1023, 32'h80000000, 32'h80000000, 1'b0));
    pending_items.push_back(mk(10'd0, 32'h0, 32'h80000000, 1'b1));
    pending_items.push_back(mk(10'd5, 32'hffffffff, 32'h1, 1'b0));
    pending_items.push_back(mk(10'd1023, 32'h7fffffff, 32'h0, 1'b1));
    pending_items.push_back(mk(10'd512, 32'h12345678, 32'hffffffff, 1'b0));
    drain();

    // zero denominator: epsilon zero on an untouched element with zero gradient
    write_reg(REG_EPSILON, 32'd0);
    write_reg(REG_INITIAL_RATE, 32'hffffffff);
    write_reg(REG_DECAY, 32'hffffff);
    write_reg(REG_BETA_FIRST, 32'd0);
    write_reg(REG_BETA_SECOND, 32'd0);
    write_reg(3'd7, 32'hdeadbeef);
    pending_items.push_back(mk(10'd700, 32'h00100000, 32'h0, 1'b0));
    pending_items.push_back(mk(10'd701, 32'h7fffffff, 32'h80000000, 1'b1));
    pending_items.push_back(mk(10'd702, 32'h80000000, 32'h7fffffff, 1'b1));
    pending_items.push_back(mk(10'd703, 32'h0, 32'h00000001, 1'b0));
    drain();
    write_reg(REG_BETA_FIRST, 32'hffffff);
    write_reg(REG_BETA_SECOND, 32'hffffff);
    write_reg(REG_EPSILON, 32'hffffffff);
    write_reg(REG_DECAY, 32'd0);
    pending_items.push_back(mk(10'd701, 32'h0, 32'h7fffffff, 1'b1));
    pending_items.push_back(mk(10'd702, 32'h0, 32'h80000000, 1'b0));
    drain();

    // random phases with varied settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_INITIAL_RATE, ph[0] ? $urandom : $urandom_range(0, 1 << 26));
      write_reg(REG_DECAY, $urandom_range(0, 24'hffffff >> (ph % 4 * 6)));
      write_reg(REG_BETA_FIRST, (ph == 3) ? 32'd0 : $urandom_range(0, 24'hffffff));
      write_reg(REG_BETA_SECOND, (ph == 5) ? 32'hffffff : $urandom_range(0, 24'hffffff));
      write_reg(REG_EPSILON, (ph == 6) ? 32'd0 : $urandom_range(0, 1 << (ph * 4)));
      for (int k = 0; k < 100; k++)
        pending_items.push_back(rand_item($urandom_range(0, 3) == 0));
      drain();
    end

    if (mismatches == 0)
      $display("tb_adam_parameter_update_core: done, clean");
    else
      $display("tb_adam_parameter_update_core: done, errors");
    $finish;
  end

endmodule
